// ----- src/srfr_pkg.sv -----
// ----------------------------------------------------------------------------
// srfr_pkg
// Shared types and constants of the servo reply frame receiver.
// ----------------------------------------------------------------------------
package srfr_pkg;

  localparam int MAX_PAYLOAD_DEF = 63;
  localparam int QUEUE_DEPTH     = 4;

  localparam logic [7:0]  SOF1       = 8'hAA;
  localparam logic [7:0]  SOF2       = 8'hCC;
  localparam logic [7:0]  EOF2       = 8'hEE;
  localparam logic [15:0] CRC16_TAPS = 16'hA001;
  localparam logic [15:0] CRC_SEED   = 16'hFFFF;

  localparam logic [7:0]  RST_ALARM   = 8'd46;
  localparam logic [7:0]  RST_RAM     = 8'd22;
  localparam logic [7:0]  RST_AXIS    = 8'd64;
  localparam logic [7:0]  RST_MOTION  = 8'd65;
  localparam logic [7:0]  RST_ALL     = 8'd67;
  localparam logic [15:0] RST_TIMEOUT = 16'd100;

  // register indexes
  localparam logic [2:0] REG_ALARM   = 3'd0;
  localparam logic [2:0] REG_RAM     = 3'd1;
  localparam logic [2:0] REG_AXIS    = 3'd2;
  localparam logic [2:0] REG_MOTION  = 3'd3;
  localparam logic [2:0] REG_ALL     = 3'd4;
  localparam logic [2:0] REG_TIMEOUT = 3'd5;

  // result kinds
  localparam logic [1:0] KIND_DATA   = 2'd0;
  localparam logic [1:0] KIND_ACCEPT = 2'd1;
  localparam logic [1:0] KIND_REJECT = 2'd2;
  localparam logic [1:0] KIND_ERROR  = 2'd3;

  // word handed from the front to the parser
  typedef struct packed {
    logic       tick;
    logic       restart;
    logic [7:0] rx_byte;
  } front_word_t;

  typedef struct packed {
    logic [7:0]  type_alarm_info;
    logic [7:0]  type_ram_param;
    logic [7:0]  type_axis_status;
    logic [7:0]  type_motion_status;
    logic [7:0]  type_all_status;
  } type_cfg_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data_byte;
    logic [5:0]  byte_index;
    logic [7:0]  drive_id;
    logic [7:0]  sync_number;
    logic [7:0]  frame_type;
    logic [7:0]  response_code;
    logic [15:0] error_count;
  } result_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ CRC16_TAPS) : (r >> 1);
    end
    return r;
  endfunction

endpackage

// ----- src/srfr_front.sv -----
// ----------------------------------------------------------------------------
// srfr_front
// Accepts words, tracks idle ticks and flags bytes that restart the search.
// ----------------------------------------------------------------------------
module srfr_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [15:0]           timeout_ticks,
  input  logic                  in_valid,
  input  logic                  op,
  input  logic [7:0]            rx_byte,
  output logic                  out_valid,
  output srfr_pkg::front_word_t out_word
);

  logic [15:0] idle_count;

  // idle tick counter, saturating
  always_ff @(posedge clk) begin
    if (rst) begin
      idle_count <= '0;
    end else if (in_valid) begin
      if (op) begin
        if (idle_count != 16'hFFFF) idle_count <= idle_count + 16'd1;
      end else begin
        idle_count <= '0;
      end
    end
  end

  // classify the word
  always_comb begin
    out_valid        = in_valid;
    out_word.tick    = op;
    out_word.restart = (idle_count >= timeout_ticks);
    out_word.rx_byte = rx_byte;
  end

endmodule

// ----- src/srfr_queue.sv -----
// ----------------------------------------------------------------------------
// srfr_queue
// Small fifo of register entries with a count.
// ----------------------------------------------------------------------------
module srfr_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full     = (count == CW'(DEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_data;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      if (do_pop)  rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      if (do_push && !do_pop)      count <= count + CW'(1);
      else if (do_pop && !do_push) count <= count - CW'(1);
    end
  end

endmodule

// ----- src/srfr_parser.sv -----
// ----------------------------------------------------------------------------
// srfr_parser
// Frame state machine, crc check and result generation.
// ----------------------------------------------------------------------------
module srfr_parser #(
  parameter int MAX_PAYLOAD = srfr_pkg::MAX_PAYLOAD_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  srfr_pkg::type_cfg_t   cfg,
  input  logic                  in_valid,
  input  srfr_pkg::front_word_t in_word,
  output logic                  in_ready,
  output logic                  res_valid,
  output srfr_pkg::result_t     res,
  input  logic                  res_full
);

  typedef enum logic [8:0] {
    ST_HEAD = 9'b000000001,
    ST_ID   = 9'b000000010,
    ST_SYNC = 9'b000000100,
    ST_TYPE = 9'b000001000,
    ST_RESP = 9'b000010000,
    ST_ESC  = 9'b000100000,
    ST_DATA = 9'b001000000,
    ST_CRC  = 9'b010000000,
    ST_TAIL = 9'b100000000
  } state_t;

  localparam int MP = (MAX_PAYLOAD > 63) ? 63 : MAX_PAYLOAD;

  state_t      state, state_next, st_eff;
  logic        pending, pending_next, pend_eff;
  logic [15:0] crc, crc_next, crc_upd;
  logic [15:0] rcrc, rcrc_next;
  logic [5:0]  pidx, pidx_next;
  logic [5:0]  plen, plen_next, len_of;
  logic [7:0]  fid, fsync, fkind, fresp;
  logic [7:0]  fid_next, fsync_next, fkind_next, fresp_next;
  logic [15:0] errs, errs_next;
  logic        emit;
  logic [1:0]  ekind;
  logic        go;
  logic [7:0]  b;

  assign in_ready = !res_full;
  assign go       = in_valid && !res_full;
  assign b        = in_word.rx_byte;
  assign crc_upd  = srfr_pkg::crc_byte(crc, b);

  // payload length from the type byte, first match wins
  always_comb begin
    if (b == cfg.type_alarm_info) len_of = 6'd1;
    else if (b == cfg.type_ram_param || b == cfg.type_axis_status) len_of = 6'd4;
    else if (b == cfg.type_motion_status) len_of = 6'd20;
    else if (b == cfg.type_all_status) len_of = (MP < 33) ? 6'(MP) : 6'd33;
    else len_of = 6'd0;
  end

  // next state
  always_comb begin
    st_eff   = in_word.restart ? ST_HEAD : state;
    pend_eff = in_word.restart ? 1'b0 : pending;
    state_next = st_eff;
    pending_next = pend_eff;
    crc_next = crc; rcrc_next = rcrc;
    pidx_next = pidx; plen_next = plen;
    fid_next = fid; fsync_next = fsync; fkind_next = fkind; fresp_next = fresp;
    errs_next = errs;
    emit = 1'b0; ekind = srfr_pkg::KIND_DATA;
    case (st_eff)
      ST_HEAD: begin
        if (b == srfr_pkg::SOF1) begin
          pending_next = 1'b1;
        end else if (pend_eff) begin
          pending_next = 1'b0;
          if (b == srfr_pkg::SOF2) begin
            state_next = ST_ID;
            crc_next   = srfr_pkg::CRC_SEED;
          end
        end
      end
      ST_ID: begin
        fid_next = b; crc_next = crc_upd; state_next = ST_SYNC;
      end
      ST_SYNC: begin
        fsync_next = b; crc_next = crc_upd; state_next = ST_TYPE;
      end
      ST_TYPE: begin
        fkind_next = b; crc_next = crc_upd; plen_next = len_of; state_next = ST_RESP;
      end
      ST_RESP: begin
        fresp_next = b; crc_next = crc_upd; pending_next = 1'b0;
        if (b != 8'd0) begin
          if (errs != 16'hFFFF) errs_next = errs + 16'd1;
          state_next = ST_HEAD;
          emit = 1'b1; ekind = srfr_pkg::KIND_ERROR;
        end else begin
          pidx_next  = '0;
          state_next = (plen != '0) ? ST_DATA : ST_CRC;
        end
      end
      ST_ESC, ST_DATA: begin
        if (st_eff == ST_DATA && b == srfr_pkg::SOF1) begin
          state_next = ST_ESC;
        end else begin
          crc_next  = crc_upd;
          pidx_next = pidx + 6'd1;
          emit = 1'b1;
          if ((pidx + 6'd1) >= plen) begin
            pending_next = 1'b0; state_next = ST_CRC;
          end else begin
            state_next = ST_DATA;
          end
        end
      end
      ST_CRC: begin
        if (pend_eff) begin
          pending_next = 1'b0;
          rcrc_next = rcrc | {b, 8'h00};
          state_next = ST_TAIL;
        end else begin
          pending_next = 1'b1;
          rcrc_next = {8'h00, b};
        end
      end
      ST_TAIL: begin
        if (b == srfr_pkg::SOF1) begin
          pending_next = 1'b1;
        end else begin
          emit = 1'b1;
          ekind = (pend_eff && b == srfr_pkg::EOF2 && crc == rcrc) ?
                  srfr_pkg::KIND_ACCEPT : srfr_pkg::KIND_REJECT;
          pending_next = 1'b0; state_next = ST_HEAD;
        end
      end
      default: begin
        state_next = ST_HEAD; pending_next = 1'b0;
      end
    endcase
  end

  // result word, frame fields taken after update
  always_comb begin
    res_valid         = go && !in_word.tick && emit;
    res.kind          = ekind;
    res.data_byte     = (ekind == srfr_pkg::KIND_DATA) ? b : 8'd0;
    res.byte_index    = (ekind == srfr_pkg::KIND_DATA) ? pidx : 6'd0;
    res.drive_id      = fid_next;
    res.sync_number   = fsync_next;
    res.frame_type    = fkind_next;
    res.response_code = fresp_next;
    res.error_count   = errs_next;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_HEAD; pending <= 1'b0; crc <= srfr_pkg::CRC_SEED; rcrc <= '0;
      pidx <= '0; plen <= '0; fid <= '0; fsync <= '0; fkind <= '0; fresp <= '0;
      errs <= '0;
    end else if (go && !in_word.tick) begin
      state <= state_next; pending <= pending_next; crc <= crc_next; rcrc <= rcrc_next;
      pidx <= pidx_next; plen <= plen_next; fid <= fid_next; fsync <= fsync_next;
      fkind <= fkind_next; fresp <= fresp_next; errs <= errs_next;
    end
  end

endmodule

// ----- src/servo_reply_frame_receiver_top.sv -----
// ----------------------------------------------------------------------------
// servo_reply_frame_receiver_top
// Reply frame receiver for a serial servo drive.
// ----------------------------------------------------------------------------
// Input channel: push a word (op 0 = byte in rx_byte, op 1 = one time tick)
// while full is low. Result channel: while empty is low the oldest result
// (payload byte, accepted, rejected or error response) sits on the result
// ports; pop takes it.
// A front stage counts idle ticks and marks bytes that restart the header
// search; a four-word queue decouples it from the frame parser, which runs
// the state machine and an unrolled crc update. A second four-word
// queue holds results.
// Throughput: one word per cycle while full is low. A result reaches the
// result ports through the word queue, the parser and the result queue.
// Reset (rst, synchronous) restores register defaults, empties both queues
// and returns the parser to header search. When the receiver stops popping
// the result queue fills, the parser stalls, then the word queue fills and
// full rises; nothing is lost.
// Registers at paddr 4*i: 0..4 type codes, 5 timeout_ticks.
// ----------------------------------------------------------------------------
module servo_reply_frame_receiver_top #(
  parameter int MAX_PAYLOAD = srfr_pkg::MAX_PAYLOAD_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        push,
  output logic        full,
  input  logic        op,
  input  logic [7:0]  rx_byte,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  kind,
  output logic [7:0]  data_byte,
  output logic [5:0]  byte_index,
  output logic [7:0]  drive_id,
  output logic [7:0]  sync_number,
  output logic [7:0]  frame_type,
  output logic [7:0]  response_code,
  output logic [15:0] error_count
);

  srfr_pkg::type_cfg_t   cfg;
  logic [15:0]           timeout_ticks;
  logic                  fr_valid;
  srfr_pkg::front_word_t fr_word, q_word;
  logic                  q_empty, q_ready, p_valid, r_full, r_empty;
  srfr_pkg::result_t     p_res, r_res;
  logic [2:0]            reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.type_alarm_info    <= srfr_pkg::RST_ALARM;
      cfg.type_ram_param     <= srfr_pkg::RST_RAM;
      cfg.type_axis_status   <= srfr_pkg::RST_AXIS;
      cfg.type_motion_status <= srfr_pkg::RST_MOTION;
      cfg.type_all_status    <= srfr_pkg::RST_ALL;
      timeout_ticks          <= srfr_pkg::RST_TIMEOUT;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        srfr_pkg::REG_ALARM:   cfg.type_alarm_info    <= pwdata[7:0];
        srfr_pkg::REG_RAM:     cfg.type_ram_param     <= pwdata[7:0];
        srfr_pkg::REG_AXIS:    cfg.type_axis_status   <= pwdata[7:0];
        srfr_pkg::REG_MOTION:  cfg.type_motion_status <= pwdata[7:0];
        srfr_pkg::REG_ALL:     cfg.type_all_status    <= pwdata[7:0];
        srfr_pkg::REG_TIMEOUT: timeout_ticks          <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    case (reg_idx)
      srfr_pkg::REG_ALARM:   prdata = {24'd0, cfg.type_alarm_info};
      srfr_pkg::REG_RAM:     prdata = {24'd0, cfg.type_ram_param};
      srfr_pkg::REG_AXIS:    prdata = {24'd0, cfg.type_axis_status};
      srfr_pkg::REG_MOTION:  prdata = {24'd0, cfg.type_motion_status};
      srfr_pkg::REG_ALL:     prdata = {24'd0, cfg.type_all_status};
      srfr_pkg::REG_TIMEOUT: prdata = {16'd0, timeout_ticks};
      default:               prdata = 32'd0;
    endcase
  end

  srfr_front u_front (
    .clk(clk), .rst(rst), .timeout_ticks(timeout_ticks),
    .in_valid(push && !full), .op(op), .rx_byte(rx_byte),
    .out_valid(fr_valid), .out_word(fr_word)
  );

  srfr_queue #(.WIDTH($bits(srfr_pkg::front_word_t)), .DEPTH(srfr_pkg::QUEUE_DEPTH)) u_wq (
    .clk(clk), .rst(rst), .push(fr_valid), .push_data(fr_word), .full(full),
    .pop(q_ready), .pop_data(q_word), .empty(q_empty)
  );

  srfr_parser #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_parser (
    .clk(clk), .rst(rst), .cfg(cfg), .in_valid(!q_empty), .in_word(q_word),
    .in_ready(q_ready), .res_valid(p_valid), .res(p_res), .res_full(r_full)
  );

  srfr_queue #(.WIDTH($bits(srfr_pkg::result_t)), .DEPTH(srfr_pkg::QUEUE_DEPTH)) u_rq (
    .clk(clk), .rst(rst), .push(p_valid), .push_data(p_res), .full(r_full),
    .pop(pop), .pop_data(r_res), .empty(r_empty)
  );

  // result ports
  assign empty         = r_empty;
  assign kind          = r_res.kind;
  assign data_byte     = r_res.data_byte;
  assign byte_index    = r_res.byte_index;
  assign drive_id      = r_res.drive_id;
  assign sync_number   = r_res.sync_number;
  assign frame_type    = r_res.frame_type;
  assign response_code = r_res.response_code;
  assign error_count   = r_res.error_count;

endmodule
